// ----- hdl/cge_pkg.sv -----
// ----------------------------------------------------------------------------
// cge_pkg
// Shared constants, codes and helper functions of the graph evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cge_pkg;

    localparam int MAX_INPUTS     = 8;
    localparam int MAX_OUTPUTS    = 4;
    localparam int MAX_ROWS       = 4;
    localparam int MAX_COLS       = 16;
    localparam int MAX_ARGS       = 4;
    localparam int FUNCTION_COUNT = 6;
    localparam int GENE_DEPTH     = MAX_COLS * MAX_ROWS * (MAX_ARGS + 1) + MAX_OUTPUTS;
    localparam int VALUE_DEPTH    = MAX_INPUTS + MAX_ROWS * MAX_COLS;
    localparam int GENE_AW        = 9;
    localparam int VALUE_AW       = 7;

    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // opcodes
    localparam logic [1:0] OP_GENE  = 2'd0;
    localparam logic [1:0] OP_INPUT = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_NUM_INPUTS  = 3'd0;
    localparam logic [2:0] REG_NUM_OUTPUTS = 3'd1;
    localparam logic [2:0] REG_NUM_ROWS    = 3'd2;
    localparam logic [2:0] REG_NUM_COLS    = 3'd3;
    localparam logic [2:0] REG_NUM_ARGS    = 3'd4;

    // node function codes
    localparam logic [6:0] FN_MIN  = 7'd0;
    localparam logic [6:0] FN_MAX  = 7'd1;
    localparam logic [6:0] FN_SUM  = 7'd2;
    localparam logic [6:0] FN_SUB  = 7'd3;
    localparam logic [6:0] FN_MUL  = 7'd4;
    localparam logic [6:0] FN_DIV  = 7'd5;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_FN_RD   = 15'b000000000000010,
        ST_FN_WAIT = 15'b000000000000100,
        ST_ARG_RD  = 15'b000000000001000,
        ST_ARG_VAL = 15'b000000000010000,
        ST_ARG_USE = 15'b000000000100000,
        ST_MUL_SAT = 15'b000000001000000,
        ST_DIV     = 15'b000000010000000,
        ST_DIV_FIX = 15'b000000100000000,
        ST_NODE_WR = 15'b000001000000000,
        ST_OUT_RD  = 15'b000010000000000,
        ST_OUT_VAL = 15'b000100000000000,
        ST_OUT_USE = 15'b001000000000000,
        ST_EMIT    = 15'b010000000000000,
        ST_SPARE   = 15'b100000000000000
    } state_t;

    function automatic logic [4:0] clamp_u5(input logic [4:0] v, input logic [4:0] lo,
                                             input logic [4:0] hi);
        logic [4:0] r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [31:0] sat_q32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > 49'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -49'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cgp_graph_evaluate_core.sv -----
// ----------------------------------------------------------------------------
// cgp_graph_evaluate_core
// Cartesian genetic programming graph evaluator, signed Q16.16 arithmetic.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         tuser[1:0] opcode; tdata slot, gene_word, sample_value
// m_*       out        tdata result_value; tuser output_number, error; tlast
// cfg_*     in         cfg_index register number, cfg_data register value
//
// An evaluation reads, per node, the function gene and each argument gene and
// value; a product adds a saturation step, and a division by a nonzero value
// runs the shared restoring divider, whose steps dominate, then a sign and
// saturation step. The output genes and values are read, then results emitted.
// s_tready is low throughout an evaluation and while results are emitted.
// Reset clears control and sets configuration to its defaults; the stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cgp_graph_evaluate_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cge_pkg::S_DATA_W-1:0]    s_tdata,   // slot, gene_word, sample_value
    input  logic [cge_pkg::S_USER_W-1:0]    s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cge_pkg::M_DATA_W-1:0]    m_tdata,   // result_value
    output logic                            m_tlast,
    output logic [cge_pkg::M_USER_W-1:0]    m_tuser,   // output_number, error
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cge_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cge_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cge_pkg::*;

    logic [GENE_AW-1:0]  in_slot;
    logic [6:0]          in_gene;
    logic signed [31:0]  in_sample;
    logic                s_fire;

    logic [3:0] num_inputs_reg;
    logic [2:0] num_outputs_reg, num_rows_reg, num_args_reg;
    logic [4:0] num_cols_reg;
    logic [3:0] ni;
    logic [2:0] no, nr, na;
    logic [4:0] nc;

    state_t state_reg, state_next;
    logic [GENE_AW-1:0]  gptr_reg, gptr_next;
    logic [VALUE_AW-1:0] wptr_reg, wptr_next;
    logic [VALUE_AW-1:0] defined_reg, defined_next;
    logic [1:0] row_reg, row_next;
    logic [3:0] col_reg, col_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] emit_reg, emit_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       err_reg, err_next;
    logic       ok_reg, ok_next;
    logic [6:0] fn_reg, fn_next;
    logic signed [34:0] acc_reg, acc_next;
    logic signed [63:0] mul_reg, mul_next;
    logic [47:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic signed [31:0] res_reg [MAX_OUTPUTS];

    logic [6:0] gene_mem [GENE_DEPTH];
    logic signed [31:0] value_mem [VALUE_DEPTH];
    logic [6:0] gene_q;
    logic signed [31:0] value_q;
    logic [GENE_AW-1:0]  gene_raddr;
    logic [VALUE_AW-1:0] value_raddr, value_waddr;
    logic                gene_we, value_we;
    logic signed [31:0]  value_wdata;

    logic signed [31:0] arg_val, acc32, node_result;
    logic               last_arg, last_row, last_col, last_out;
    logic [32:0]        rem_sh;
    logic signed [48:0] div_signed;
    logic               res_we;

    assign in_slot   = s_tdata[8:0];
    assign in_gene   = s_tdata[15:9];
    assign in_sample = s_tdata[47:16];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign ni = 4'(clamp_u5({1'b0, num_inputs_reg}, 5'd1, 5'(MAX_INPUTS)));
    assign no = 3'(clamp_u5({2'b0, num_outputs_reg}, 5'd1, 5'(MAX_OUTPUTS)));
    assign nr = 3'(clamp_u5({2'b0, num_rows_reg}, 5'd1, 5'(MAX_ROWS)));
    assign nc = clamp_u5(num_cols_reg, 5'd1, 5'(MAX_COLS));
    assign na = 3'(clamp_u5({2'b0, num_args_reg}, 5'd2, 5'(MAX_ARGS)));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_inputs_reg  <= 4'd1;
            num_outputs_reg <= 3'd1;
            num_rows_reg    <= 3'd1;
            num_cols_reg    <= 5'd1;
            num_args_reg    <= 3'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NUM_INPUTS:  num_inputs_reg  <= cfg_data[3:0];
                REG_NUM_OUTPUTS: num_outputs_reg <= cfg_data[2:0];
                REG_NUM_ROWS:    num_rows_reg    <= cfg_data[2:0];
                REG_NUM_COLS:    num_cols_reg    <= cfg_data;
                REG_NUM_ARGS:    num_args_reg    <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // stores
    assign gene_we    = s_fire && (s_tuser == OP_GENE) && (in_slot < 9'(GENE_DEPTH));
    assign gene_raddr = gptr_reg + ((state_reg == ST_FN_RD) ? {6'b0, na} : {7'b0, k_reg});

    always_ff @(posedge clk)
    begin
        if (gene_we)
            gene_mem[in_slot] <= in_gene;
        gene_q <= gene_mem[gene_raddr];
    end

    assign value_we    = (s_fire && (s_tuser == OP_INPUT) && (in_slot < 9'(MAX_INPUTS)))
                         || (state_reg == ST_NODE_WR);
    assign value_waddr = (state_reg == ST_NODE_WR) ? wptr_reg : in_slot[VALUE_AW-1:0];
    assign value_wdata = (state_reg == ST_NODE_WR) ? node_result : in_sample;
    assign value_raddr = (gene_q < 7'(VALUE_DEPTH)) ? gene_q : '0;

    always_ff @(posedge clk)
    begin
        if (value_we)
            value_mem[value_waddr] <= value_wdata;
        value_q <= value_mem[value_raddr];
    end

    assign arg_val     = ok_reg ? value_q : 32'sd0;
    assign acc32       = acc_reg[31:0];
    assign node_result = (fn_reg < 7'(FUNCTION_COUNT)) ? sat_q32(49'(acc_reg)) : 32'sd0;
    assign last_arg    = ({1'b0, k_reg} == na - 3'd1);
    assign last_out    = ({1'b0, k_reg} == no - 3'd1);
    assign last_row    = ({1'b0, row_reg} == nr - 3'd1);
    assign last_col    = ({1'b0, col_reg} == nc - 5'd1);
    assign rem_sh      = {rem_reg, dvd_reg[47]};
    assign div_signed  = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign res_we      = (state_reg == ST_OUT_USE);

    always_comb
    begin
        state_next   = state_reg;
        gptr_next    = gptr_reg;
        wptr_next    = wptr_reg;
        defined_next = defined_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        k_next       = k_reg;
        emit_next    = emit_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        ok_next      = ok_reg;
        fn_next      = fn_reg;
        acc_next     = acc_reg;
        mul_next     = mul_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dsr_next     = dsr_reg;
        neg_next     = neg_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_tuser == OP_EVAL))
                begin
                    gptr_next    = '0;
                    wptr_next    = 7'(ni);
                    defined_next = 7'(ni);
                    row_next     = '0;
                    col_next     = '0;
                    k_next       = '0;
                    err_next     = 1'b0;
                    state_next   = ST_FN_RD;
                end
            end
            ST_FN_RD:
                state_next = ST_FN_WAIT;
            ST_FN_WAIT:
            begin
                fn_next    = gene_q;
                k_next     = '0;
                state_next = ST_ARG_RD;
            end
            ST_ARG_RD:
                state_next = ST_ARG_VAL;
            ST_ARG_VAL:
            begin
                ok_next    = (gene_q < defined_reg);
                state_next = ST_ARG_USE;
            end
            ST_ARG_USE:
            begin
                if (!ok_reg)
                    err_next = 1'b1;
                state_next = last_arg ? ST_NODE_WR : ST_ARG_RD;
                k_next     = last_arg ? k_reg : k_reg + 2'd1;
                if (k_reg == 2'd0)
                    acc_next = 35'(arg_val);
                else
                begin
                    priority case (fn_reg)
                        FN_MIN: if (35'(arg_val) < acc_reg) acc_next = 35'(arg_val);
                        FN_MAX: if (35'(arg_val) > acc_reg) acc_next = 35'(arg_val);
                        FN_SUM: acc_next = acc_reg + 35'(arg_val);
                        FN_SUB: acc_next = acc_reg - 35'(arg_val);
                        FN_MUL:
                        begin
                            mul_next   = 64'(acc32) * 64'(arg_val);
                            state_next = ST_MUL_SAT;
                            k_next     = k_reg;
                        end
                        FN_DIV:
                        begin
                            if (arg_val != 32'sd0)
                            begin
                                neg_next   = acc32[31] ^ arg_val[31];
                                dvd_next   = {abs32(acc32), 16'b0};
                                dsr_next   = abs32(arg_val);
                                rem_next   = '0;
                                cnt_next   = '0;
                                state_next = ST_DIV;
                                k_next     = k_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL_SAT:
            begin
                // floor of product / 65536
                acc_next   = 35'(sat_q32(49'($signed(mul_reg[63:16]))));
                state_next = last_arg ? ST_NODE_WR : ST_ARG_RD;
                k_next     = last_arg ? k_reg : k_reg + 2'd1;
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, dsr_reg})
                begin
                    rem_next = 32'(rem_sh - {1'b0, dsr_reg});
                    dvd_next = {dvd_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    dvd_next = {dvd_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                    state_next = ST_DIV_FIX;
            end
            ST_DIV_FIX:
            begin
                acc_next   = 35'(sat_q32(div_signed));
                state_next = last_arg ? ST_NODE_WR : ST_ARG_RD;
                k_next     = last_arg ? k_reg : k_reg + 2'd1;
            end
            ST_NODE_WR:
            begin
                wptr_next = wptr_reg + 7'd1;
                gptr_next = gptr_reg + 9'(na) + 9'd1;
                k_next    = '0;
                if (last_row)
                begin
                    row_next     = '0;
                    defined_next = defined_reg + 7'(nr);
                    col_next     = col_reg + 4'd1;
                    state_next   = last_col ? ST_OUT_RD : ST_FN_RD;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = ST_FN_RD;
                end
            end
            ST_OUT_RD:
                state_next = ST_OUT_VAL;
            ST_OUT_VAL:
            begin
                ok_next    = (gene_q < defined_reg);
                state_next = ST_OUT_USE;
            end
            ST_OUT_USE:
            begin
                if (!ok_reg)
                    err_next = 1'b1;
                if (last_out)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_OUT_RD;
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    if (m_tlast)
                        state_next = ST_IDLE;
                    else
                        emit_next = emit_reg + 2'd1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            gptr_reg    <= '0;
            wptr_reg    <= '0;
            defined_reg <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            k_reg       <= '0;
            emit_reg    <= '0;
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gptr_reg    <= gptr_next;
            wptr_reg    <= wptr_next;
            defined_reg <= defined_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            k_reg       <= k_next;
            emit_reg    <= emit_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            ok_reg      <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fn_reg  <= fn_next;
        acc_reg <= acc_next;
        mul_reg <= mul_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
        if (res_we)
            res_reg[k_reg] <= arg_val;
    end

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = res_reg[emit_reg];
    assign m_tlast  = ({1'b0, emit_reg} == no - 3'd1);
    assign m_tuser  = {err_reg, emit_reg};

endmodule

`default_nettype wire

// ----- hdl/cge_checker.sv -----
// ----------------------------------------------------------------------------
// cge_checker
// Port-level checks on the graph evaluator, bound to cgp_graph_evaluate_core.
// ----------------------------------------------------------------------------
`default_nettype none

module cge_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cge_pkg::M_DATA_W-1:0]    m_tdata,
    input logic                            m_tlast,
    input logic [cge_pkg::M_USER_W-1:0]    m_tuser
);
    import cge_pkg::*;

    // no input is taken while results are on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while results pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid
            && (m_tuser[1:0] == $past(m_tuser[1:0]) + 2'd1)
            && (m_tuser[2] == $past(m_tuser[2])))
        else $error("result sequence broken");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("evaluation did not end after last result");

endmodule

bind cgp_graph_evaluate_core cge_checker u_cge_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
